### rtl/core/obrf_pkg.sv
// Shared types, constants and helpers for the overwriting byte ring FIFO.
`timescale 1ns / 1ps
package obrf_pkg;

    localparam int DEPTH    = 1024;
    localparam int MAX_READ = 64;

    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CAP_W   = $clog2(DEPTH + 1);
    localparam int CFG_W   = 11;
    localparam int CMD_W   = 2;
    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 7;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 10;

    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NO_DATA  = 2'd2;

    typedef logic [ADDR_W-1:0] t_ptr;
    typedef logic [CAP_W-1:0]  t_cap;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic accept;   // input request taken this cycle
        logic pop;      // emit one burst byte this cycle
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_free;     // output register can load this cycle
        logic burst_start;  // pending request is a legal read burst
        logic last_pop;     // next burst byte is the final one
    } t_dp_stat;

    // step a ring pointer, wrapping at the capacity in use
    function automatic t_ptr f_advance(input t_ptr p, input t_cap cap);
        t_cap nx;
        nx = CAP_W'(p) + CAP_W'(1);
        return (nx >= cap) ? '0 : nx[ADDR_W-1:0];
    endfunction

endpackage

### rtl/core/obrf_ctrl.sv
// Controller state machine: request acceptance and read burst sequencing.
`timescale 1ns / 1ps
module obrf_ctrl
    import obrf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_in_stall
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_stat.out_free && i_stat.burst_start) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                if (i_stat.out_free && i_stat.last_pop) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.accept = 1'b0;
        o_cmd.pop    = 1'b0;
        o_in_stall   = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall   = !i_stat.out_free;
                o_cmd.accept = i_in_valid && i_stat.out_free;
            end
            ST_READ: begin
                o_cmd.pop = i_stat.out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

### rtl/core/obrf_dp.sv
// Datapath: byte store, ring pointers, fill count and result register.
`timescale 1ns / 1ps
module obrf_dp
    import obrf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [CMD_W-1:0]   i_command,
    input  logic [BYTE_W-1:0]  i_write_byte,
    input  logic [LEN_W-1:0]   i_read_length,
    input  logic               i_cfg_we,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic               i_out_stall,
    input  t_dp_cmd            i_cmd,
    output t_dp_stat           o_stat,
    output logic               o_out_valid,
    output logic [BYTE_W-1:0]  o_read_byte,
    output logic               o_byte_valid,
    output logic               o_last_of_run,
    output logic [STAT_W-1:0]  o_status,
    output logic [COUNT_W-1:0] o_fill_count,
    output logic [COUNT_W-1:0] o_free_space
);

    logic [BYTE_W-1:0] mem [DEPTH];

    t_cap             r_cap;
    t_ptr             r_head, n_head;
    t_ptr             r_tail, n_tail;
    t_ptr             r_fill, n_fill;
    logic [LEN_W-1:0] r_count, n_count;
    logic [BYTE_W-1:0] r_rd_data;

    logic               r_out_valid;
    logic [BYTE_W-1:0]  r_out_byte, n_out_byte;
    logic               r_out_bvalid, n_out_bvalid;
    logic               r_out_last, n_out_last;
    logic [STAT_W-1:0]  r_out_status, n_out_status;
    logic [COUNT_W-1:0] r_out_fill;
    logic [COUNT_W-1:0] r_out_free;

    logic load_out;
    logic full;
    logic rd_ok;
    logic mem_we;
    t_cap clamp_cap;
    t_cap free_next;

    assign full  = (CAP_W'(r_fill) == r_cap - CAP_W'(1));
    assign rd_ok = (i_read_length != '0) && (i_read_length <= LEN_W'(MAX_READ))
                   && (CAP_W'(i_read_length) <= CAP_W'(r_fill));

    assign o_stat.out_free    = !r_out_valid || !i_out_stall;
    assign o_stat.burst_start = (i_command == CMD_READ) && rd_ok;
    assign o_stat.last_pop    = (r_count == LEN_W'(1));

    assign mem_we = i_cmd.accept && (i_command == CMD_WRITE);

    always_comb begin
        if (i_cfg_data < CFG_W'(2)) begin
            clamp_cap = CAP_W'(2);
        end else if (32'(i_cfg_data) > DEPTH) begin
            clamp_cap = CAP_W'(DEPTH);
        end else begin
            clamp_cap = CAP_W'(i_cfg_data);
        end
    end

    always_comb begin
        n_head       = r_head;
        n_tail       = r_tail;
        n_fill       = r_fill;
        n_count      = r_count;
        n_out_byte   = '0;
        n_out_bvalid = 1'b0;
        n_out_last   = 1'b1;
        n_out_status = STAT_OK;
        load_out     = 1'b0;
        if (i_cmd.pop) begin
            load_out     = 1'b1;
            n_out_byte   = r_rd_data;
            n_out_bvalid = 1'b1;
            n_out_last   = o_stat.last_pop;
            n_tail       = f_advance(r_tail, r_cap);
            n_fill       = r_fill - ADDR_W'(1);
            n_count      = r_count - LEN_W'(1);
        end else if (i_cmd.accept) begin
            load_out = 1'b1;
            unique case (i_command)
                CMD_WRITE: begin
                    n_head = f_advance(r_head, r_cap);
                    if (full) begin
                        // drop oldest: tail moves one past the new head
                        n_tail       = f_advance(n_head, r_cap);
                        n_out_status = STAT_OVERFLOW;
                    end else begin
                        n_fill = r_fill + ADDR_W'(1);
                    end
                end
                CMD_READ: begin
                    if (rd_ok) begin
                        load_out = 1'b0;
                        n_count  = i_read_length;
                    end else if (i_read_length != '0) begin
                        n_out_status = STAT_NO_DATA;
                    end
                end
                CMD_CLEAR: begin
                    n_head = '0;
                    n_tail = '0;
                    n_fill = '0;
                end
                default: begin
                end
            endcase
        end
        if (i_cfg_we) begin
            n_head = '0;
            n_tail = '0;
            n_fill = '0;
        end
    end

    assign free_next = r_cap - CAP_W'(1) - CAP_W'(n_fill);

    // byte store; the read port tracks the next tail so burst bytes stream out
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_head] <= i_write_byte;
        end
        r_rd_data <= mem[n_tail];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_W'(DEPTH);
            r_head      <= '0;
            r_tail      <= '0;
            r_fill      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= clamp_cap;
            end
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_fill  <= n_fill;
            r_count <= n_count;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_byte   <= n_out_byte;
            r_out_bvalid <= n_out_bvalid;
            r_out_last   <= n_out_last;
            r_out_status <= n_out_status;
            r_out_fill   <= COUNT_W'(n_fill);
            r_out_free   <= COUNT_W'(free_next);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_read_byte   = r_out_byte;
    assign o_byte_valid  = r_out_bvalid;
    assign o_last_of_run = r_out_last;
    assign o_status      = r_out_status;
    assign o_fill_count  = r_out_fill;
    assign o_free_space  = r_out_free;

endmodule

### rtl/core/overwriting_byte_ring_fifo_core.sv
// Top level of the overwriting byte ring FIFO: controller and datapath.
//
// Input channel (i_in_valid / o_in_stall) carries one request: write a byte,
// read a burst of i_read_length bytes, or clear. Output channel
// (o_out_valid / i_out_stall) carries results, each with fill count and
// free space as they stand after that result.
// A write, clear, rejected read or zero-length read gives one result in the
// cycle after it is taken; such requests are taken every cycle while the
// output register drains. A legal read gives one result per byte: the first
// byte goes through the registered read port of the byte store and the
// output register, then one follows per cycle while i_out_stall is low; the
// next request is taken once the last byte has loaded the output register.
// That read port follows the next tail pointer and sets the burst rate.
// Writing full drops the oldest byte and flags overflow. A capacity write
// (i_cfg_we) empties the ring; issue it only while idle.
// Reset empties the ring, sets capacity to the full depth and drops any
// pending result. While i_out_stall is high the result holds and o_in_stall
// rises, so no request is lost.
`timescale 1ns / 1ps
module overwriting_byte_ring_fifo_core
    import obrf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [CMD_W-1:0]   i_command,
    input  logic [BYTE_W-1:0]  i_write_byte,
    input  logic [LEN_W-1:0]   i_read_length,
    input  logic               i_cfg_we,
    input  logic [CFG_W-1:0]   i_cfg_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [BYTE_W-1:0]  o_read_byte,
    output logic               o_byte_valid,
    output logic               o_last_of_run,
    output logic [STAT_W-1:0]  o_status,
    output logic [COUNT_W-1:0] o_fill_count,
    output logic [COUNT_W-1:0] o_free_space
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    obrf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd),
        .o_in_stall (o_in_stall)
    );

    obrf_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_command     (i_command),
        .i_write_byte  (i_write_byte),
        .i_read_length (i_read_length),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_out_stall   (i_out_stall),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .o_out_valid   (o_out_valid),
        .o_read_byte   (o_read_byte),
        .o_byte_valid  (o_byte_valid),
        .o_last_of_run (o_last_of_run),
        .o_status      (o_status),
        .o_fill_count  (o_fill_count),
        .o_free_space  (o_free_space)
    );

endmodule

### rtl/core/obrf_checker.sv
// Port-level assertions for the overwriting byte ring FIFO, bound to the top.
`timescale 1ns / 1ps
module obrf_checker
    import obrf_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [BYTE_W-1:0]  o_read_byte,
    input logic               o_byte_valid,
    input logic               o_last_of_run,
    input logic [STAT_W-1:0]  o_status,
    input logic [COUNT_W-1:0] o_fill_count
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_read_byte)
            && $stable(o_last_of_run) && $stable(o_status) && $stable(o_fill_count))
        else $error("stalled result changed");

    // delivered bytes always carry ok status
    a_byte_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_byte_valid |-> o_status == STAT_OK)
        else $error("delivered byte with error status");

    // a result without a byte closes its run and carries a zero byte
    a_nobyte_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_byte_valid |-> o_last_of_run && o_read_byte == '0)
        else $error("non-byte result malformed");

    // reset drops any pending result
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind overwriting_byte_ring_fifo_core obrf_checker u_obrf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_read_byte   (o_read_byte),
    .o_byte_valid  (o_byte_valid),
    .o_last_of_run (o_last_of_run),
    .o_status      (o_status),
    .o_fill_count  (o_fill_count)
);

### verif/tb.sv
// Self-checking testbench for the overwriting byte ring FIFO core.
`timescale 1ns / 1ps
module tb;
    import obrf_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int               RUN_LIMIT  = 200000;
    localparam int               DRAIN_WAIT = 10;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [BYTE_W-1:0] wbyte;
        logic [LEN_W-1:0]  len;
    } t_request;

    typedef struct packed {
        logic [BYTE_W-1:0]  rbyte;
        logic               bvalid;
        logic               last;
        logic [STAT_W-1:0]  status;
        logic [COUNT_W-1:0] fill;
        logic [COUNT_W-1:0] room;
    } t_ring_result;

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               in_valid      = 1'b0;
    logic               in_stall;
    logic [CMD_W-1:0]   command       = CMD_WRITE;
    logic [BYTE_W-1:0]  write_byte    = '0;
    logic [LEN_W-1:0]   read_length   = '0;
    logic               cfg_we        = 1'b0;
    logic [CFG_W-1:0]   cfg_data      = '0;
    logic               out_valid;
    logic               out_stall     = 1'b0;
    logic [BYTE_W-1:0]  read_byte;
    logic               byte_valid;
    logic               last_of_run;
    logic [STAT_W-1:0]  status;
    logic [COUNT_W-1:0] fill_count;
    logic [COUNT_W-1:0] free_space;

    overwriting_byte_ring_fifo_core dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_command     (command),
        .i_write_byte  (write_byte),
        .i_read_length (read_length),
        .i_cfg_we      (cfg_we),
        .i_cfg_data    (cfg_data),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_read_byte   (read_byte),
        .o_byte_valid  (byte_valid),
        .o_last_of_run (last_of_run),
        .o_status      (status),
        .o_fill_count  (fill_count),
        .o_free_space  (free_space)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    t_request     request_q[$];
    t_ring_result ring_results_q[$];
    int           requests_queued   = 0;
    int           requests_accepted = 0;
    int           errors            = 0;
    int           cycle_count       = 0;
    int           send_idle_pct     = 0;
    int           recv_idle_pct     = 0;

    // shadow ring
    logic [BYTE_W-1:0] ring_mem [DEPTH];
    int unsigned       ring_head = 0;
    int unsigned       ring_tail = 0;
    int unsigned       ring_cap  = DEPTH;

    // fill level tracked while planning stimulus
    int unsigned plan_fill = 0;
    int unsigned plan_cap  = DEPTH;

    function automatic int unsigned ring_held();
        if (ring_head >= ring_tail) return ring_head - ring_tail;
        return ring_cap - ring_tail + ring_head;
    endfunction

    function automatic int unsigned ring_next(int unsigned p);
        return (p + 1 >= ring_cap) ? 0 : p + 1;
    endfunction

    function automatic void push_ring_result(logic [BYTE_W-1:0] b, logic v, logic last,
                                             logic [STAT_W-1:0] st);
        t_ring_result r;
        int unsigned  fill;
        fill     = ring_held();
        r.rbyte  = b;
        r.bvalid = v;
        r.last   = last;
        r.status = st;
        r.fill   = COUNT_W'(fill);
        r.room   = COUNT_W'(ring_cap - 1 - fill);
        ring_results_q.push_back(r);
    endfunction

    function automatic void ring_apply_request(t_request rq);
        logic        full;
        int unsigned n;
        n = rq.len;
        case (rq.cmd)
            CMD_WRITE: begin
                full = (ring_held() == ring_cap - 1);
                ring_mem[ring_head] = rq.wbyte;
                ring_head = ring_next(ring_head);
                // drop the oldest byte
                if (full) ring_tail = ring_next(ring_head);
                push_ring_result('0, 1'b0, 1'b1, full ? STAT_OVERFLOW : STAT_OK);
            end
            CMD_READ: begin
                if (n == 0) begin
                    push_ring_result('0, 1'b0, 1'b1, STAT_OK);
                end else if (n > MAX_READ || n > ring_held()) begin
                    push_ring_result('0, 1'b0, 1'b1, STAT_NO_DATA);
                end else begin
                    for (int k = 0; k < n; k++) begin
                        logic [BYTE_W-1:0] b;
                        b = ring_mem[ring_tail];
                        ring_tail = ring_next(ring_tail);
                        push_ring_result(b, 1'b1, (k + 1 == n), STAT_OK);
                    end
                end
            end
            CMD_CLEAR: begin
                ring_head = 0;
                ring_tail = 0;
                push_ring_result('0, 1'b0, 1'b1, STAT_OK);
            end
            default: push_ring_result('0, 1'b0, 1'b1, STAT_OK);
        endcase
    endfunction

    function automatic void queue_request(logic [CMD_W-1:0] c, logic [BYTE_W-1:0] b,
                                          logic [LEN_W-1:0] n);
        t_request rq;
        rq.cmd   = c;
        rq.wbyte = b;
        rq.len   = n;
        request_q.push_back(rq);
        requests_queued++;
        case (c)
            CMD_WRITE: if (plan_fill < plan_cap - 1) plan_fill++;
            CMD_READ:  if (n != 0 && n <= MAX_READ && n <= plan_fill) plan_fill -= n;
            CMD_CLEAR: plan_fill = 0;
            default: ;
        endcase
    endfunction

    // mostly writes and legal bursts, with some noise mixed in
    function automatic void queue_random(int count, int write_pct);
        int          r;
        int unsigned top;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            top = (plan_fill < MAX_READ) ? plan_fill : MAX_READ;
            if (r < write_pct) begin
                queue_request(CMD_WRITE, BYTE_W'($urandom), '0);
            end else if (r < write_pct + 30 && top > 0) begin
                queue_request(CMD_READ, BYTE_W'($urandom), LEN_W'($urandom_range(1, top)));
            end else if (r < 96) begin
                queue_request(CMD_READ, BYTE_W'($urandom), LEN_W'($urandom_range(0, 127)));
            end else if (r < 98) begin
                queue_request(CMD_CLEAR, BYTE_W'($urandom), LEN_W'($urandom));
            end else begin
                queue_request(CMD_UNUSED, BYTE_W'($urandom), LEN_W'($urandom));
            end
        end
    endfunction

    task automatic wait_idle();
        do @(posedge clk);
        while (requests_accepted != requests_queued || ring_results_q.size() != 0);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_capacity(logic [CFG_W-1:0] value);
        int unsigned v;
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        v = value;
        if (v < 2) v = 2;
        if (v > DEPTH) v = DEPTH;
        ring_cap  = v;
        ring_head = 0;
        ring_tail = 0;
        plan_cap  = v;
        plan_fill = 0;
    endtask

    // request driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                ring_apply_request('{command, write_byte, read_length});
                requests_accepted++;
            end
            if (!in_valid || !in_stall) begin
                if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    t_request rq;
                    rq = request_q.pop_front();
                    in_valid    <= 1'b1;
                    command     <= rq.cmd;
                    write_byte  <= rq.wbyte;
                    read_length <= rq.len;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result receiver
    always @(posedge clk) begin
        out_stall <= rst_n && ($urandom_range(99) < recv_idle_pct);
    end

    // result monitor
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (ring_results_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: byte %0h v %0b last %0b st %0d fill %0d free %0d",
                             read_byte, byte_valid, last_of_run, status, fill_count,
                             free_space);
            end else begin
                t_ring_result e;
                e = ring_results_q.pop_front();
                if (read_byte !== e.rbyte || byte_valid !== e.bvalid ||
                    last_of_run !== e.last || status !== e.status ||
                    fill_count !== e.fill || free_space !== e.room) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp byte %0h v %0b last %0b st %0d fill %0d free %0d%s",
                                 e.rbyte, e.bvalid, e.last, e.status, e.fill, e.room,
                                 $sformatf(" / got byte %0h v %0b last %0b st %0d fill %0d free %0d",
                                           read_byte, byte_valid, last_of_run, status,
                                           fill_count, free_space));
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 25;
        recv_idle_pct = 56;

        // below range: taken as a two-slot ring holding one byte
        write_capacity(11'd0);
        queue_request(CMD_WRITE, 8'h00, 7'd0);
        queue_request(CMD_WRITE, 8'hFF, 7'd0);
        queue_request(CMD_READ, 8'h00, 7'd1);
        queue_request(CMD_READ, 8'h00, 7'd1);
        queue_request(CMD_READ, 8'h00, 7'd0);
        queue_request(CMD_WRITE, 8'hA5, 7'd0);
        queue_request(CMD_READ, 8'h00, 7'd2);
        queue_request(CMD_READ, 8'hFF, 7'd127);
        queue_request(CMD_READ, 8'h00, 7'd65);
        queue_request(CMD_UNUSED, 8'hFF, 7'd127);
        queue_request(CMD_CLEAR, 8'h00, 7'd0);
        queue_request(CMD_READ, 8'h00, 7'd1);
        queue_request(CMD_WRITE, 8'h5A, 7'd0);
        queue_request(CMD_WRITE, 8'h3C, 7'd0);
        queue_request(CMD_UNUSED, 8'h00, 7'd0);
        queue_request(CMD_READ, 8'h00, 7'd1);
        // leave a byte behind; the next capacity write must empty the ring
        queue_request(CMD_WRITE, 8'h81, 7'd0);
        wait_idle();

        // above range: taken as the full depth
        write_capacity(11'h7FF);
        queue_request(CMD_READ, 8'h00, 7'd1);
        for (int i = 0; i < 66; i++) queue_request(CMD_WRITE, BYTE_W'($urandom), '0);
        queue_request(CMD_READ, 8'h00, 7'd64);
        queue_random(30, 50);
        wait_idle();

        send_idle_pct = 56;
        recv_idle_pct = 25;
        write_capacity(11'd5);
        queue_random(45, 50);
        wait_idle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_capacity(11'd17);
        queue_random(45, 55);
        wait_idle();

        write_capacity(11'd1024);
        queue_random(10, 60);
        wait_idle();

        write_capacity(11'd1);
        queue_random(15, 50);
        wait_idle();

        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### overwriting_byte_ring_fifo_core.f
rtl/core/obrf_pkg.sv
rtl/core/obrf_ctrl.sv
rtl/core/obrf_dp.sv
rtl/core/overwriting_byte_ring_fifo_core.sv
rtl/core/obrf_checker.sv
verif/tb.sv
